// ===== hdl/servo_button_position_one_touch_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SERVO_BUTTON_POSITION_ONE_TOUCH_ASSERT_SVH
`define SERVO_BUTTON_POSITION_ONE_TOUCH_ASSERT_SVH

// Check a property while out of reset.
`define SBPOT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sbpot assertion failed");

// Check a property at every edge, reset included.
`define SBPOT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sbpot assertion failed");

`endif

// ===== hdl/sbpot_pkg.sv =====
`timescale 1ns / 1ps
package sbpot_pkg;

  localparam int ANGLE_W = 8;
  localparam int HOLD_W  = 16;
  localparam int LPT_W   = 16;
  localparam int PULSE_W = 15;
  localparam int PW_W    = 16;
  localparam int PROD_W  = ANGLE_W + PULSE_W;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LONG_PRESS = 2'd0;
  localparam cfg_idx_t REG_PULSE_BASE = 2'd1;
  localparam cfg_idx_t REG_PULSE_SPAN = 2'd2;

  localparam logic [LPT_W-1:0]   LONG_PRESS_RST = 16'd30;
  localparam logic [PULSE_W-1:0] PULSE_BASE_RST = 15'd500;
  localparam logic [PULSE_W-1:0] PULSE_SPAN_RST = 15'd2000;
  localparam logic [ANGLE_W-1:0] ANGLE_RST      = 8'd90;

endpackage

// ===== hdl/sbpot_if.sv =====
`timescale 1ns / 1ps
interface sbpot_in_if;
  logic valid;
  logic ready;
  logic down_pressed;
  logic up_pressed;
  modport source (output valid, output down_pressed, output up_pressed, input ready);
  modport sink (input valid, input down_pressed, input up_pressed, output ready);
endinterface

interface sbpot_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbpot_pkg::ANGLE_W-1:0] angle;
  logic [sbpot_pkg::PW_W-1:0]    pulse_width;
  modport source (output valid, output angle, output pulse_width, input ready);
  modport sink (input valid, input angle, input pulse_width, output ready);
endinterface

// ===== hdl/servo_button_position_one_touch.sv =====
`timescale 1ns / 1ps
// Two-button servo positioner with one-touch auto travel.
// in_if carries one tick per transaction: down_pressed and up_pressed.
// out_if returns one transaction per tick: the angle after the tick and
// the servo pulse compare value pulse_base + pulse_span * angle / MAX_ANGLE,
// saturated at 16 bits.
// Registers (APB, byte address 4*i): 0 long_press_ticks, 1 pulse_base,
// 2 pulse_span. Write only while no tick is in flight.
// A tick taken passes the state update, span product, reciprocal multiply,
// then base add in the output register. Throughput is one tick per cycle
// while the receiver takes results; the state update is a loop through
// the state registers and the two multiplies are pipelined behind it.
// Reset (rst_n low, synchronous): angle 90, hold counters and auto flags
// cleared, registers at 30 / 500 / 2000, pipeline emptied.
// When the receiver stalls, the result holds in the output register and
// the stages behind it keep filling; in_if.ready drops only once every
// stage holds a result.
module servo_button_position_one_touch #(
  parameter int MAX_ANGLE = 180
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sbpot_in_if.sink                      in_if,
  sbpot_out_if.source                   out_if,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sbpot_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [sbpot_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [sbpot_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int AW   = sbpot_pkg::ANGLE_W;
  localparam int HW   = sbpot_pkg::HOLD_W;
  localparam int PRW  = sbpot_pkg::PROD_W;
  localparam int SH   = PRW + $clog2(MAX_ANGLE);
  localparam longint RECIP = ((64'd1 << SH) + MAX_ANGLE - 1) / MAX_ANGLE;
  localparam int MW   = PRW + 1;
  localparam logic [AW-1:0] MAX_A = AW'(MAX_ANGLE);

  logic [sbpot_pkg::LPT_W-1:0]   long_press_r;
  logic [sbpot_pkg::PULSE_W-1:0] pulse_base_r;
  logic [sbpot_pkg::PULSE_W-1:0] pulse_span_r;

  logic [AW-1:0] angle_r, angle_nxt;
  logic [HW-1:0] down_cnt_r, down_cnt_nxt;
  logic [HW-1:0] up_cnt_r, up_cnt_nxt;
  logic          auto_down_r, auto_down_nxt;
  logic          auto_up_r, auto_up_nxt;

  logic           s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic [AW-1:0]  s2_angle_r, s3_angle_r, out_angle_r;
  logic [PRW-1:0] s2_prod_r, s3_quot_r;
  logic [sbpot_pkg::PW_W-1:0] out_pw_r;

  logic rdy_out, rdy3, rdy2, rdy1, in_take;
  logic [PRW+MW-1:0] recip_prod;
  logic [PRW:0]      pw_sum;
  logic              cfg_wr;
  sbpot_pkg::cfg_idx_t cfg_idx;

  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      sbpot_pkg::REG_LONG_PRESS: cfg_prdata = sbpot_pkg::CFG_DW'(long_press_r);
      sbpot_pkg::REG_PULSE_BASE: cfg_prdata = sbpot_pkg::CFG_DW'(pulse_base_r);
      sbpot_pkg::REG_PULSE_SPAN: cfg_prdata = sbpot_pkg::CFG_DW'(pulse_span_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_press_r <= sbpot_pkg::LONG_PRESS_RST;
      pulse_base_r <= sbpot_pkg::PULSE_BASE_RST;
      pulse_span_r <= sbpot_pkg::PULSE_SPAN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sbpot_pkg::REG_LONG_PRESS: long_press_r <= cfg_pwdata[sbpot_pkg::LPT_W-1:0];
        sbpot_pkg::REG_PULSE_BASE: pulse_base_r <= cfg_pwdata[sbpot_pkg::PULSE_W-1:0];
        sbpot_pkg::REG_PULSE_SPAN: pulse_span_r <= cfg_pwdata[sbpot_pkg::PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign rdy_out      = !out_valid_r || out_if.ready;
  assign rdy3         = !s3_valid_r || rdy_out;
  assign rdy2         = !s2_valid_r || rdy3;
  assign rdy1         = !s1_valid_r || rdy2;
  assign in_if.ready  = rdy1;
  assign in_take      = in_if.valid && rdy1;

  always_comb begin
    angle_nxt     = angle_r;
    auto_down_nxt = auto_down_r;
    auto_up_nxt   = auto_up_r;
    down_cnt_nxt  = down_cnt_r;
    up_cnt_nxt    = up_cnt_r;
    if (in_if.down_pressed) begin
      auto_down_nxt = 1'b0;
      auto_up_nxt   = 1'b0;
      if (angle_nxt != '0) angle_nxt = angle_nxt - 1'b1;
      if (down_cnt_r != '1) down_cnt_nxt = down_cnt_r + 1'b1;
    end else begin
      if (down_cnt_r >= long_press_r) auto_down_nxt = 1'b1;
      down_cnt_nxt = '0;
    end
    if (in_if.up_pressed) begin
      auto_down_nxt = 1'b0;
      auto_up_nxt   = 1'b0;
      if (angle_nxt < MAX_A) angle_nxt = angle_nxt + 1'b1;
      if (up_cnt_r != '1) up_cnt_nxt = up_cnt_r + 1'b1;
    end else begin
      if (up_cnt_r >= long_press_r) auto_up_nxt = 1'b1;
      up_cnt_nxt = '0;
    end
    if (auto_down_nxt) begin
      if (angle_nxt != '0) angle_nxt = angle_nxt - 1'b1;
      else auto_down_nxt = 1'b0;
    end
    if (auto_up_nxt) begin
      if (angle_nxt < MAX_A) angle_nxt = angle_nxt + 1'b1;
      else auto_up_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r     <= sbpot_pkg::ANGLE_RST;
      down_cnt_r  <= '0;
      up_cnt_r    <= '0;
      auto_down_r <= 1'b0;
      auto_up_r   <= 1'b0;
    end else if (in_take) begin
      angle_r     <= angle_nxt;
      down_cnt_r  <= down_cnt_nxt;
      up_cnt_r    <= up_cnt_nxt;
      auto_down_r <= auto_down_nxt;
      auto_up_r   <= auto_up_nxt;
    end
  end

  assign recip_prod = s2_prod_r * MW'(RECIP);
  assign pw_sum     = (PRW+1)'(pulse_base_r) + (PRW+1)'(s3_quot_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) s1_valid_r <= in_if.valid;
      if (rdy2) s2_valid_r <= s1_valid_r;
      if (rdy3) s3_valid_r <= s2_valid_r;
      if (rdy_out) out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_valid_r) begin
      s2_angle_r <= angle_r;
      s2_prod_r  <= angle_r * pulse_span_r;
    end
    if (rdy3 && s2_valid_r) begin
      s3_angle_r <= s2_angle_r;
      s3_quot_r  <= PRW'(recip_prod >> SH);
    end
    if (rdy_out && s3_valid_r) begin
      out_angle_r <= s3_angle_r;
      out_pw_r    <= (pw_sum[PRW:sbpot_pkg::PW_W] != '0) ? '1 : pw_sum[sbpot_pkg::PW_W-1:0];
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.angle       = out_angle_r;
  assign out_if.pulse_width = out_pw_r;

endmodule

// ===== hdl/sbpot_checker.sv =====
`timescale 1ns / 1ps
`include "servo_button_position_one_touch_assert.svh"
module sbpot_checker #(
  parameter int MAX_ANGLE = 180
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [sbpot_pkg::ANGLE_W-1:0] out_angle,
  input logic [sbpot_pkg::PW_W-1:0]    out_pulse_width,
  input logic                          cfg_pready
);

  localparam int TOP = (MAX_ANGLE > 90) ? MAX_ANGLE : 90;
  localparam logic [sbpot_pkg::ANGLE_W-1:0] TOP_A = sbpot_pkg::ANGLE_W'(TOP);

  logic [sbpot_pkg::ANGLE_W-1:0] last_angle_r;
  logic [sbpot_pkg::ANGLE_W:0]   angle_diff;

  assign angle_diff = (out_angle >= last_angle_r)
                      ? (sbpot_pkg::ANGLE_W+1)'(out_angle - last_angle_r)
                      : (sbpot_pkg::ANGLE_W+1)'(last_angle_r - out_angle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_angle_r <= sbpot_pkg::ANGLE_RST;
    end else if (out_valid && out_ready) begin
      last_angle_r <= out_angle;
    end
  end

  `SBPOT_ASSERT_ALWAYS(a_empty_after_reset, clk, $past(!rst_n) |-> !out_valid)
  `SBPOT_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)
  `SBPOT_ASSERT(a_angle_range, clk, rst_n, out_valid |-> out_angle <= TOP_A)
  `SBPOT_ASSERT(a_angle_slew, clk, rst_n, (out_valid && out_ready) |-> angle_diff <= 2)
  `SBPOT_ASSERT(a_hold_stalled, clk, rst_n,
    (out_valid && !out_ready) |=> (out_valid && $stable(out_pulse_width)))

  logic unused_ok;
  assign unused_ok = in_valid & cfg_pready;

endmodule

bind servo_button_position_one_touch sbpot_checker #(.MAX_ANGLE(MAX_ANGLE)) u_sbpot_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_angle       (out_if.angle),
  .out_pulse_width (out_if.pulse_width),
  .cfg_pready      (cfg_pready)
);
